>>> hw/rtl/lsca_pkg.sv
package lsca_pkg;

   localparam int SENSORS        = 8;
   localparam int WINDOW_DEFAULT = 10;

   localparam int IDX_W   = 3;
   localparam int RAW_W   = 8;
   localparam int CODE_W  = 10;
   localparam int WHITE_W = 11;
   localparam int BLACK_W = 10;
   localparam int VAL_W   = 11;
   localparam int AVG_W   = 15;
   localparam int OFFS_W  = 17;

   localparam int FULL_SCALE_INT = 1024;
   localparam logic [VAL_W-1:0] FULL_SCALE = VAL_W'(FULL_SCALE_INT);

   // restoring divider, one quotient bit per step
   localparam int DIV_STEPS = CODE_W;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] REG_WHITE_LEVEL = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_BLACK_LEVEL = CSR_INDEX_W'(1);

   typedef struct packed {
      logic capture;
      logic calib;
      logic div_step;
      logic update;
      logic mul;
      logic qest;
      logic corr;
      logic load_out;
   } lsca_cmd_type;

   typedef struct packed {
      logic div_done;
   } lsca_sts_type;

endpackage

>>> hw/rtl/lsca_ctrl.sv
module lsca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  lsca_pkg::lsca_sts_type sts,
   output lsca_pkg::lsca_cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CALIB  = 8'b0000_0010,
      ST_DIV    = 8'b0000_0100,
      ST_UPDATE = 8'b0000_1000,
      ST_MUL    = 8'b0001_0000,
      ST_QEST   = 8'b0010_0000,
      ST_CORR   = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } lsca_state_type;

   lsca_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_CALIB;
            end
         end
         ST_CALIB: begin
            cmd.calib = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_QEST;
         end
         ST_QEST: begin
            cmd.qest = 1'b1;
            state_in = ST_CORR;
         end
         ST_CORR: begin
            cmd.corr = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            cmd.load_out = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/lsca_dp.sv
module lsca_dp #(
   parameter int WINDOW = lsca_pkg::WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lsca_pkg::lsca_cmd_type               cmd,
   output lsca_pkg::lsca_sts_type               sts,
   input  logic [lsca_pkg::IDX_W-1:0]           req_sensor_index,
   input  logic [lsca_pkg::RAW_W-1:0]           req_raw_high,
   input  logic [lsca_pkg::RAW_W-1:0]           req_raw_low,
   input  logic                                 csr_write,
   input  logic [lsca_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lsca_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic [lsca_pkg::IDX_W-1:0]           rsp_echo_index,
   output logic [lsca_pkg::AVG_W-1:0]           rsp_filtered_value,
   output logic signed [lsca_pkg::OFFS_W-1:0]   rsp_lateral_offset,
   output logic                                 rsp_offset_valid
);

   localparam int IDX_W   = lsca_pkg::IDX_W;
   localparam int CODE_W  = lsca_pkg::CODE_W;
   localparam int WHITE_W = lsca_pkg::WHITE_W;
   localparam int BLACK_W = lsca_pkg::BLACK_W;
   localparam int VAL_W   = lsca_pkg::VAL_W;
   localparam int AVG_W   = lsca_pkg::AVG_W;
   localparam int OFFS_W  = lsca_pkg::OFFS_W;
   localparam int CNT_W   = lsca_pkg::CNT_W;
   localparam int SENSORS = lsca_pkg::SENSORS;

   localparam int DEPTH  = SENSORS * WINDOW;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int POS_W  = $clog2(WINDOW);
   localparam int SUM_W  = $clog2(WINDOW * lsca_pkg::FULL_SCALE_INT + 1);
   localparam int X_W    = SUM_W + 4;
   localparam int PROD_W = 2 * X_W;
   localparam logic [X_W-1:0] RECIP = X_W'((2 ** X_W) / WINDOW);

   // configuration
   logic [WHITE_W-1:0] white_ff;
   logic [BLACK_W-1:0] black_ff;

   // captured word
   logic [IDX_W-1:0]  idx_ff;
   logic [CODE_W-1:0] code_ff;

   // calibration divider
   logic [VAL_W-1:0]   q_ff, q_in;
   logic [WHITE_W-1:0] rem_ff, rem_in;
   logic [WHITE_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               is_white, is_black;
   logic [WHITE_W:0]   rem_sh, rem_sub;
   logic               fits;

   // sample store
   logic [VAL_W-1:0]  mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [ADDR_W-1:0] addr_ff, rd_addr;
   logic [VAL_W-1:0]  rd_ff;

   // per-sensor state
   logic [SUM_W-1:0] sum_ff [SENSORS];
   logic [POS_W-1:0] pos_ff [SENSORS];
   logic [AVG_W-1:0] avg_ff [SENSORS];
   logic [VAL_W-1:0] old_val;
   logic [SUM_W-1:0] sum_new;
   logic [POS_W-1:0] pos_cur, pos_nxt;

   // average by reciprocal
   logic [X_W-1:0]    x_val, r_val;
   logic [PROD_W-1:0] prod_ff;
   logic [AVG_W-1:0]  q0_ff, avg_new;
   logic [X_W-1:0]    qw_ff;
   logic [X_W-1:0]    q_est;

   // offset
   logic [AVG_W:0]    pos_pair, neg_pair;
   logic [OFFS_W-1:0] offs_new;

   // output word
   logic [IDX_W-1:0]  echo_ff;
   logic [AVG_W-1:0]  fval_ff;
   logic [OFFS_W-1:0] offs_ff;
   logic              ovld_ff;

   assign is_white = {1'b0, code_ff} >= white_ff;
   assign is_black = code_ff <= black_ff;
   assign rem_sh   = {rem_ff, 1'b0};
   assign fits     = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub  = rem_sh - {1'b0, dvs_ff};
   assign sts.div_done = (cnt_ff == '0);

   always_comb begin
      q_in   = q_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (cmd.calib) begin
         rem_in = {1'b0, code_ff} - {1'b0, black_ff};
         dvs_in = white_ff - {1'b0, black_ff};
         priority if (is_white) begin
            q_in   = lsca_pkg::FULL_SCALE;
            cnt_in = '0;
         end else if (is_black) begin
            q_in   = '0;
            cnt_in = '0;
         end else begin
            q_in   = '0;
            cnt_in = CNT_W'(lsca_pkg::DIV_STEPS);
         end
      end else if (cmd.div_step && (cnt_ff != '0)) begin
         q_in   = {q_ff[VAL_W-2:0], fits};
         rem_in = fits ? rem_sub[WHITE_W-1:0] : rem_sh[WHITE_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   assign rd_addr = ADDR_W'(idx_ff * WINDOW) + ADDR_W'(pos_ff[idx_ff]);
   assign old_val = vld_ff[addr_ff] ? rd_ff : '0;
   assign sum_new = sum_ff[idx_ff] - SUM_W'(old_val) + SUM_W'(q_ff);
   assign pos_cur = pos_ff[idx_ff];
   assign pos_nxt = (pos_cur == POS_W'(WINDOW - 1)) ? '0 : pos_cur + POS_W'(1);

   assign x_val   = {sum_ff[idx_ff], 4'b0000};
   assign q_est   = prod_ff[PROD_W-1:X_W];
   assign r_val   = x_val - qw_ff;
   assign avg_new = (r_val >= X_W'(WINDOW)) ? q0_ff + AVG_W'(1) : q0_ff;

   assign pos_pair = {1'b0, avg_ff[1]} + {1'b0, avg_ff[5]};
   assign neg_pair = {1'b0, avg_ff[2]} + {1'b0, avg_ff[6]};
   assign offs_new = {1'b0, pos_pair} - {1'b0, neg_pair};

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff <= lsca_pkg::FULL_SCALE;
         black_ff <= '0;
         cnt_ff   <= '0;
         vld_ff   <= '0;
         for (int s = 0; s < SENSORS; s++) begin
            sum_ff[s] <= '0;
            pos_ff[s] <= '0;
            avg_ff[s] <= '0;
         end
      end else begin
         cnt_ff <= cnt_in;
         if (csr_write) begin
            unique case (csr_index)
               lsca_pkg::REG_WHITE_LEVEL: white_ff <= csr_wdata[WHITE_W-1:0];
               lsca_pkg::REG_BLACK_LEVEL: black_ff <= csr_wdata[BLACK_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.update) begin
            vld_ff[addr_ff] <= 1'b1;
            sum_ff[idx_ff]  <= sum_new;
            pos_ff[idx_ff]  <= pos_nxt;
         end
         if (cmd.corr) begin
            avg_ff[idx_ff] <= avg_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (cmd.capture) begin
         idx_ff  <= req_sensor_index;
         code_ff <= {req_raw_high[1:0], req_raw_low};
      end
      if (cmd.calib) begin
         addr_ff <= rd_addr;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(x_val) * PROD_W'(RECIP);
      end
      if (cmd.qest) begin
         q0_ff <= AVG_W'(q_est);
         qw_ff <= X_W'(q_est * WINDOW);
      end
      if (cmd.load_out) begin
         echo_ff <= idx_ff;
         fval_ff <= avg_ff[idx_ff];
         ovld_ff <= (idx_ff == IDX_W'(SENSORS - 1));
         offs_ff <= (idx_ff == IDX_W'(SENSORS - 1)) ? offs_new : '0;
      end
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (cmd.calib) begin
         rd_ff <= mem[rd_addr];
      end
      if (cmd.update) begin
         mem[addr_ff] <= q_ff;
      end
   end

   assign rsp_echo_index     = echo_ff;
   assign rsp_filtered_value = fval_ff;
   assign rsp_lateral_offset = $signed(offs_ff);
   assign rsp_offset_valid   = ovld_ff;

endmodule

>>> hw/rtl/line_sensor_calibrate_average.sv
// channel  direction  handshake              word
// req      in         req_valid / req_ready  sensor_index, raw_high, raw_low
// rsp      out        rsp_valid / rsp_ready  echo_index, filtered_value, lateral_offset,
//                                            offset_valid
// csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// one word at a time; a code between the levels runs the 10-step divider, while a code
// at or beyond a level is clamped and skips the divider steps
// the next word waits until the previous result is loaded into the output register
// the output register holds a result while the next word is taken in
// synchronous reset sets white level to full scale; clears black level, sums, positions, averages, sample valid bits
// csr_ready is always high
module line_sensor_calibrate_average #(
   parameter int WINDOW = lsca_pkg::WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lsca_pkg::IDX_W-1:0]           req_sensor_index,
   input  logic [lsca_pkg::RAW_W-1:0]           req_raw_high,
   input  logic [lsca_pkg::RAW_W-1:0]           req_raw_low,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lsca_pkg::IDX_W-1:0]           rsp_echo_index,
   output logic [lsca_pkg::AVG_W-1:0]           rsp_filtered_value,
   output logic signed [lsca_pkg::OFFS_W-1:0]   rsp_lateral_offset,
   output logic                                 rsp_offset_valid,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lsca_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lsca_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   lsca_pkg::lsca_cmd_type cmd;
   lsca_pkg::lsca_sts_type sts;

   assign csr_ready = 1'b1;

   lsca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lsca_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_sensor_index   (req_sensor_index),
      .req_raw_high       (req_raw_high),
      .req_raw_low        (req_raw_low),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_echo_index     (rsp_echo_index),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_lateral_offset (rsp_lateral_offset),
      .rsp_offset_valid   (rsp_offset_valid)
   );

endmodule
